// ===== rtl/packet_byte_accounting_by_address_class_assert.svh =====
// Assertion macros used by the checker of this block.
`ifndef PACKET_BYTE_ACCOUNTING_BY_ADDRESS_CLASS_ASSERT_SVH
`define PACKET_BYTE_ACCOUNTING_BY_ADDRESS_CLASS_ASSERT_SVH

// Same-cycle implication, sampled on clock, off while reset is high.
`define PBAC_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off while reset is high.
`define PBAC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/pbac_pkg.sv =====
package pbac_pkg;

   localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
   localparam logic [15:0] ETYPE_IPV6 = 16'h86DD;
   localparam logic [15:0] MIN_LEN_V4 = 16'd34;
   localparam logic [15:0] MIN_LEN_V6 = 16'd54;

   // Which running total a counted packet goes to: {egress, private}.
   typedef enum logic [1:0] {
      SEL_IN_PUB   = 2'b00,
      SEL_IN_PRIV  = 2'b01,
      SEL_OUT_PUB  = 2'b10,
      SEL_OUT_PRIV = 2'b11
   } total_sel_type;

   typedef struct packed {
      logic          counted;
      logic          priv;
      total_sel_type sel;
      logic [15:0]   frame_len;
   } class_type;

   typedef struct packed {
      logic [63:0] out_public;
      logic [63:0] out_private;
      logic [63:0] in_public;
      logic [63:0] in_private;
   } totals_type;

endpackage

// ===== rtl/pbac_classify.sv =====
module pbac_classify
   import pbac_pkg::*;
(
   input  logic        egress,
   input  logic [15:0] ethertype,
   input  logic [15:0] frame_len,
   input  logic [15:0] captured_len,
   input  logic [31:0] v4_source,
   input  logic [31:0] v4_dest,
   input  logic [63:0] v6_source_high,
   input  logic [63:0] v6_source_low,
   input  logic [63:0] v6_dest_high,
   input  logic [63:0] v6_dest_low,
   output class_type   cls
);

   logic [31:0] v4_addr;
   logic [63:0] v6_high;
   logic [63:0] v6_low;
   logic [7:0]  o0_v4;
   logic [7:0]  o1_v4;
   logic [7:0]  o0_v6;
   logic [7:0]  o1_v6;
   logic        v4_ok;
   logic        v6_ok;
   logic        v4_priv;
   logic        v6_priv;

   // Egress classifies destination, ingress classifies source.
   assign v4_addr = egress ? v4_dest : v4_source;
   assign v6_high = egress ? v6_dest_high : v6_source_high;
   assign v6_low  = egress ? v6_dest_low : v6_source_low;

   assign o0_v4 = v4_addr[31:24];
   assign o1_v4 = v4_addr[23:16];
   assign o0_v6 = v6_high[63:56];
   assign o1_v6 = v6_high[55:48];

   assign v4_ok = (ethertype == ETYPE_IPV4) && (captured_len >= MIN_LEN_V4);
   assign v6_ok = (ethertype == ETYPE_IPV6) && (captured_len >= MIN_LEN_V6);

   assign v4_priv = (o0_v4 == 8'd0) || (o0_v4 == 8'd10) || (o0_v4 == 8'd127)
                 || ((o0_v4 == 8'd172) && ((o1_v4 & 8'hF0) == 8'h10))
                 || ((o0_v4 == 8'd192) && (o1_v4 == 8'd168))
                 || ((o0_v4 == 8'd169) && (o1_v4 == 8'd254))
                 || ((o0_v4 == 8'd100) && ((o1_v4 & 8'hC0) == 8'h40))
                 || ((o0_v4 & 8'hF0) == 8'hE0)
                 || (v4_addr == 32'hFFFF_FFFF);

   assign v6_priv = (o0_v6 == 8'hFF)
                 || ((o0_v6 == 8'hFE) && ((o1_v6 & 8'hC0) == 8'h80))
                 || ((o0_v6 & 8'hFE) == 8'hFC)
                 || ((v6_high == 64'd0) && (v6_low == 64'd1));

   always_comb begin
      cls.counted   = v4_ok || v6_ok;
      cls.priv      = v4_ok ? v4_priv : (v6_ok && v6_priv);
      cls.sel       = total_sel_type'({egress, cls.priv});
      cls.frame_len = frame_len;
   end

endmodule

// ===== rtl/pbac_accum.sv =====
module pbac_accum
   import pbac_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  class_type  cls,
   output logic       counted,
   output logic       is_private,
   output totals_type totals
);

   totals_type  totals_ff;
   totals_type  totals_in;
   logic        counted_ff;
   logic        priv_ff;
   logic [63:0] sel_total;
   logic [63:0] sum;

   always_comb begin
      unique case (cls.sel)
         SEL_IN_PUB:   sel_total = totals_ff.in_public;
         SEL_IN_PRIV:  sel_total = totals_ff.in_private;
         SEL_OUT_PUB:  sel_total = totals_ff.out_public;
         SEL_OUT_PRIV: sel_total = totals_ff.out_private;
         default:      sel_total = totals_ff.in_public;
      endcase
   end

   assign sum = sel_total + {48'd0, cls.frame_len};

   always_comb begin
      totals_in = totals_ff;
      if (load && cls.counted) begin
         unique case (cls.sel)
            SEL_IN_PUB:   totals_in.in_public   = sum;
            SEL_IN_PRIV:  totals_in.in_private  = sum;
            SEL_OUT_PUB:  totals_in.out_public  = sum;
            SEL_OUT_PRIV: totals_in.out_private = sum;
            default:      totals_in = totals_ff;
         endcase
      end
   end

   // The totals double as the result register: they change only on a load.
   always_ff @(posedge clock) begin
      if (reset) begin
         totals_ff <= '0;
      end else begin
         totals_ff <= totals_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         counted_ff <= cls.counted;
         priv_ff    <= cls.counted && cls.priv;
      end
   end

   assign counted    = counted_ff;
   assign is_private = priv_ff;
   assign totals     = totals_ff;

endmodule

// ===== rtl/packet_byte_accounting_by_address_class.sv =====
// A req transfer is registered in the classify stage, then in the count stage, which drives rsp_valid.
// Throughput: one packet per cycle while rsp_stall is low; the count stage holds one 64-bit add per packet.
// A req transfer is still taken while a result waits on rsp_stall, if the classify stage is empty.
// Reset (synchronous, active high) empties both stages and clears all four totals to zero.
module packet_byte_accounting_by_address_class
   import pbac_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_egress,
   input  logic [15:0] req_ethertype,
   input  logic [15:0] req_frame_len,
   input  logic [15:0] req_captured_len,
   input  logic [31:0] req_v4_source,
   input  logic [31:0] req_v4_dest,
   input  logic [63:0] req_v6_source_high,
   input  logic [63:0] req_v6_source_low,
   input  logic [63:0] req_v6_dest_high,
   input  logic [63:0] req_v6_dest_low,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_counted,
   output logic        rsp_is_private,
   output logic [63:0] rsp_egress_public_bytes,
   output logic [63:0] rsp_egress_private_bytes,
   output logic [63:0] rsp_ingress_public_bytes,
   output logic [63:0] rsp_ingress_private_bytes
);

   class_type  cls;
   class_type  stage_ff;
   logic       stage_valid_ff;
   logic       stage_valid_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       out_ready;
   logic       advance;
   logic       req_take;
   totals_type totals;

   pbac_classify u_classify (
      .egress         (req_egress),
      .ethertype      (req_ethertype),
      .frame_len      (req_frame_len),
      .captured_len   (req_captured_len),
      .v4_source      (req_v4_source),
      .v4_dest        (req_v4_dest),
      .v6_source_high (req_v6_source_high),
      .v6_source_low  (req_v6_source_low),
      .v6_dest_high   (req_v6_dest_high),
      .v6_dest_low    (req_v6_dest_low),
      .cls            (cls)
   );

   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign advance   = stage_valid_ff && out_ready;
   assign req_stall = stage_valid_ff && !out_ready;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      stage_valid_in = stage_valid_ff;
      if (advance || !stage_valid_ff) begin
         stage_valid_in = req_take;
      end
      rsp_valid_in = rsp_valid_ff;
      if (out_ready) begin
         rsp_valid_in = advance;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Hold the classified packet until the count stage takes it.
   always_ff @(posedge clock) begin
      if (req_take) begin
         stage_ff <= cls;
      end
   end

   pbac_accum u_accum (
      .clock      (clock),
      .reset      (reset),
      .load       (advance),
      .cls        (stage_ff),
      .counted    (rsp_counted),
      .is_private (rsp_is_private),
      .totals     (totals)
   );

   assign rsp_valid                 = rsp_valid_ff;
   assign rsp_egress_public_bytes   = totals.out_public;
   assign rsp_egress_private_bytes  = totals.out_private;
   assign rsp_ingress_public_bytes  = totals.in_public;
   assign rsp_ingress_private_bytes = totals.in_private;

endmodule

// ===== rtl/pbac_checker.sv =====
`include "packet_byte_accounting_by_address_class_assert.svh"

module pbac_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        req_egress,
   input logic [15:0] req_ethertype,
   input logic [15:0] req_frame_len,
   input logic [15:0] req_captured_len,
   input logic [31:0] req_v4_source,
   input logic [31:0] req_v4_dest,
   input logic [63:0] req_v6_source_high,
   input logic [63:0] req_v6_source_low,
   input logic [63:0] req_v6_dest_high,
   input logic [63:0] req_v6_dest_low,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_counted,
   input logic        rsp_is_private,
   input logic [63:0] rsp_egress_public_bytes,
   input logic [63:0] rsp_egress_private_bytes,
   input logic [63:0] rsp_ingress_public_bytes,
   input logic [63:0] rsp_ingress_private_bytes
);

   logic [255:0] totals_now;
   logic [255:0] totals_seen_ff;
   logic [3:0]   total_moved;

   assign totals_now = {rsp_egress_public_bytes, rsp_egress_private_bytes,
                        rsp_ingress_public_bytes, rsp_ingress_private_bytes};

   // Keep last cycle's totals to spot which ones moved.
   always_ff @(posedge clock) begin
      totals_seen_ff <= totals_now;
   end

   assign total_moved = {totals_now[255:192] != totals_seen_ff[255:192],
                         totals_now[191:128] != totals_seen_ff[191:128],
                         totals_now[127:64]  != totals_seen_ff[127:64],
                         totals_now[63:0]    != totals_seen_ff[63:0]};

   `PBAC_ASSERT_NEXT(a_rsp_held, rsp_valid && rsp_stall, rsp_valid, "stalled result dropped")
   `PBAC_ASSERT_NOW(a_priv_counted, rsp_valid && rsp_is_private, rsp_counted, "private but not counted")
   `PBAC_ASSERT_NOW(a_no_stall_when_empty, !rsp_valid, !req_stall, "input stalled with empty output")
   `PBAC_ASSERT_NEXT(a_one_total_moves, 1'b1, ($countones(total_moved) <= 1), "more than one total changed")

endmodule

bind packet_byte_accounting_by_address_class pbac_checker u_pbac_checker (.*);

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps

module testbench
   import pbac_pkg::*;
();

   typedef struct {
      logic        egress;
      logic [15:0] ethertype;
      logic [15:0] frame_len;
      logic [15:0] captured_len;
      logic [31:0] v4_source;
      logic [31:0] v4_dest;
      logic [63:0] v6_source_high;
      logic [63:0] v6_source_low;
      logic [63:0] v6_dest_high;
      logic [63:0] v6_dest_low;
   } packet_desc_type;

   typedef struct {
      logic       counted;
      logic       is_private;
      totals_type totals;
   } byte_report_type;

   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   localparam int unsigned CYCLE_LIMIT = 200000;
   localparam int HOLD_OFF_CYCLES = 200;

   localparam logic [31:0] V4_PROBES [12] = '{
      32'h0000_0000, 32'h0A00_0001, 32'h7F00_0001, 32'hAC1F_FFFF,
      32'hAC20_0000, 32'hC0A8_0001, 32'hA9FE_0101, 32'h6440_0000,
      32'h6480_0000, 32'hEFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFE
   };

   localparam logic [127:0] V6_PROBES [7] = '{
      128'h1,
      128'h0,
      128'hFE80_0000_0000_0000_0000_0000_0000_0001,
      128'hFEC0_0000_0000_0000_0000_0000_0000_0001,
      128'hFC00_0000_0000_0000_0000_0000_0000_0000,
      128'hFF02_0000_0000_0000_0000_0000_0000_0001,
      128'h2001_0DB8_0000_0000_0000_0000_0000_0001
   };

   // Tracks the four byte totals and the results still owed by the block.
   class address_class_ledger;
      totals_type      totals;
      byte_report_type expected_reports [$];
      int unsigned     failures;

      function new();
         totals = '0;
         failures = 0;
      endfunction

      function bit v4_private(logic [31:0] addr);
         logic [7:0] o0;
         logic [7:0] o1;
         o0 = addr[31:24];
         o1 = addr[23:16];
         return o0 == 8'd0 || o0 == 8'd10 || o0 == 8'd127
            || (o0 == 8'd172 && o1[7:4] == 4'h1)
            || (o0 == 8'd192 && o1 == 8'd168)
            || (o0 == 8'd169 && o1 == 8'd254)
            || (o0 == 8'd100 && o1[7:6] == 2'b01)
            || o0[7:4] == 4'hE
            || addr == 32'hFFFF_FFFF;
      endfunction

      function bit v6_private(logic [63:0] hi, logic [63:0] lo);
         logic [7:0] o0;
         logic [7:0] o1;
         o0 = hi[63:56];
         o1 = hi[55:48];
         return o0 == 8'hFF
            || (o0 == 8'hFE && o1[7:6] == 2'b10)
            || o0[7:1] == 7'b1111110
            || (hi == 64'd0 && lo == 64'd1);
      endfunction

      function byte_report_type account_packet(packet_desc_type p);
         byte_report_type rpt;
         logic            priv;
         logic            ok;
         total_sel_type   sel;
         priv = 1'b0;
         ok = 1'b0;
         if (p.ethertype == ETYPE_IPV4 && p.captured_len >= MIN_LEN_V4) begin
            ok = 1'b1;
            priv = v4_private(p.egress ? p.v4_dest : p.v4_source);
         end else if (p.ethertype == ETYPE_IPV6 && p.captured_len >= MIN_LEN_V6) begin
            ok = 1'b1;
            priv = p.egress ? v6_private(p.v6_dest_high, p.v6_dest_low)
                            : v6_private(p.v6_source_high, p.v6_source_low);
         end
         if (ok) begin
            sel = total_sel_type'({p.egress, priv});
            case (sel)
               SEL_OUT_PUB:  totals.out_public  += 64'(p.frame_len);
               SEL_OUT_PRIV: totals.out_private += 64'(p.frame_len);
               SEL_IN_PUB:   totals.in_public   += 64'(p.frame_len);
               SEL_IN_PRIV:  totals.in_private  += 64'(p.frame_len);
            endcase
         end
         rpt.counted = ok;
         rpt.is_private = ok & priv;
         rpt.totals = totals;
         return rpt;
      endfunction

      function void note_packet(packet_desc_type p);
         expected_reports.push_back(account_packet(p));
      endfunction

      function void flag(string what, logic [63:0] want, logic [63:0] got);
         if (failures < 10)
            $display("mismatch at %0t: %s expected %h got %h", $realtime, what, want, got);
         failures++;
      endfunction

      function void check_report(byte_report_type seen);
         byte_report_type want;
         if (expected_reports.size() == 0) begin
            flag("transfer with nothing outstanding, counted", 64'd0, 64'(seen.counted));
            return;
         end
         want = expected_reports.pop_front();
         if (seen.counted !== want.counted)
            flag("counted", 64'(want.counted), 64'(seen.counted));
         if (seen.is_private !== want.is_private)
            flag("is_private", 64'(want.is_private), 64'(seen.is_private));
         if (seen.totals.out_public !== want.totals.out_public)
            flag("egress_public_bytes", want.totals.out_public, seen.totals.out_public);
         if (seen.totals.out_private !== want.totals.out_private)
            flag("egress_private_bytes", want.totals.out_private, seen.totals.out_private);
         if (seen.totals.in_public !== want.totals.in_public)
            flag("ingress_public_bytes", want.totals.in_public, seen.totals.in_public);
         if (seen.totals.in_private !== want.totals.in_private)
            flag("ingress_private_bytes", want.totals.in_private, seen.totals.in_private);
      endfunction

      function int pending();
         return expected_reports.size();
      endfunction
   endclass

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_egress = 1'b0;
   logic [15:0] req_ethertype = '0;
   logic [15:0] req_frame_len = '0;
   logic [15:0] req_captured_len = '0;
   logic [31:0] req_v4_source = '0;
   logic [31:0] req_v4_dest = '0;
   logic [63:0] req_v6_source_high = '0;
   logic [63:0] req_v6_source_low = '0;
   logic [63:0] req_v6_dest_high = '0;
   logic [63:0] req_v6_dest_low = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_counted;
   logic        rsp_is_private;
   logic [63:0] rsp_egress_public_bytes;
   logic [63:0] rsp_egress_private_bytes;
   logic [63:0] rsp_ingress_public_bytes;
   logic [63:0] rsp_ingress_private_bytes;

   address_class_ledger ledger;
   idle_mode_type       idle_mode = IDLE_NONE;
   bit                  hold_off_start = 1'b0;
   int unsigned         cycle_count = 0;

   packet_byte_accounting_by_address_class DUT (
      .clock                     (clock),
      .reset                     (reset),
      .req_valid                 (req_valid),
      .req_stall                 (req_stall),
      .req_egress                (req_egress),
      .req_ethertype             (req_ethertype),
      .req_frame_len             (req_frame_len),
      .req_captured_len          (req_captured_len),
      .req_v4_source             (req_v4_source),
      .req_v4_dest               (req_v4_dest),
      .req_v6_source_high        (req_v6_source_high),
      .req_v6_source_low         (req_v6_source_low),
      .req_v6_dest_high          (req_v6_dest_high),
      .req_v6_dest_low           (req_v6_dest_low),
      .rsp_valid                 (rsp_valid),
      .rsp_stall                 (rsp_stall),
      .rsp_counted               (rsp_counted),
      .rsp_is_private            (rsp_is_private),
      .rsp_egress_public_bytes   (rsp_egress_public_bytes),
      .rsp_egress_private_bytes  (rsp_egress_private_bytes),
      .rsp_ingress_public_bytes  (rsp_ingress_public_bytes),
      .rsp_ingress_private_bytes (rsp_ingress_private_bytes)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Check results before noting new packets so a stray result never meets a fresh entry.
   always @(posedge clock) begin : monitor
      packet_desc_type seen_pkt;
      byte_report_type seen_rpt;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            seen_rpt.counted = rsp_counted;
            seen_rpt.is_private = rsp_is_private;
            seen_rpt.totals.out_public = rsp_egress_public_bytes;
            seen_rpt.totals.out_private = rsp_egress_private_bytes;
            seen_rpt.totals.in_public = rsp_ingress_public_bytes;
            seen_rpt.totals.in_private = rsp_ingress_private_bytes;
            ledger.check_report(seen_rpt);
         end
         if (req_valid && !req_stall) begin
            seen_pkt.egress = req_egress;
            seen_pkt.ethertype = req_ethertype;
            seen_pkt.frame_len = req_frame_len;
            seen_pkt.captured_len = req_captured_len;
            seen_pkt.v4_source = req_v4_source;
            seen_pkt.v4_dest = req_v4_dest;
            seen_pkt.v6_source_high = req_v6_source_high;
            seen_pkt.v6_source_low = req_v6_source_low;
            seen_pkt.v6_dest_high = req_v6_dest_high;
            seen_pkt.v6_dest_low = req_v6_dest_low;
            ledger.note_packet(seen_pkt);
         end
      end
   end

   // Receiver: random stalls per idle mode, or one long hold-off when asked.
   initial begin : receiver
      int held;
      held = 0;
      forever begin
         @(posedge clock);
         if (hold_off_start) begin
            hold_off_start = 1'b0;
            held = HOLD_OFF_CYCLES;
         end
         if (held > 0) begin
            rsp_stall <= 1'b1;
            held--;
         end else begin
            rsp_stall <= $urandom_range(0, 99) < ((idle_mode == IDLE_RECEIVER) ? 46 :
                                                  (idle_mode == IDLE_BOTH) ? 8 : 0);
         end
      end
   end

   function automatic logic [31:0] random_v4();
      logic [31:0] addr;
      addr = $urandom;
      case ($urandom_range(0, 12))
         0: addr[31:24] = 8'd0;
         1: addr[31:24] = 8'd10;
         2: addr[31:24] = 8'd127;
         3: addr[31:20] = {8'd172, 4'h1};
         4: addr[31:24] = 8'd172;
         5: addr[31:16] = {8'd192, 8'd168};
         6: addr[31:16] = {8'd169, 8'd254};
         7: addr[31:22] = {8'd100, 2'b01};
         8: addr[31:24] = 8'd100;
         9: addr[31:28] = 4'hE;
         10: addr[31:1] = 31'h7FFF_FFFF; // broadcast or its neighbor
         default: ;
      endcase
      return addr;
   endfunction

   function automatic logic [127:0] random_v6();
      logic [127:0] addr;
      addr = {$urandom, $urandom, $urandom, $urandom};
      case ($urandom_range(0, 9))
         0: addr[127:120] = 8'hFF;
         1: addr[127:118] = {8'hFE, 2'b10};
         2: addr[127:120] = 8'hFE;
         3: addr[127:121] = 7'b1111110;
         4: addr = 128'd1;
         5: addr[127:2] = '0; // loopback and its neighbors
         6: addr[127:64] = '0;
         default: ;
      endcase
      return addr;
   endfunction

   function automatic packet_desc_type random_packet();
      packet_desc_type p;
      logic [127:0]    src6;
      logic [127:0]    dst6;
      int              pick;
      pick = $urandom_range(0, 99);
      src6 = random_v6();
      dst6 = random_v6();
      p.egress = 1'($urandom_range(0, 1));
      p.frame_len = 16'($urandom);
      p.v4_source = random_v4();
      p.v4_dest = random_v4();
      p.v6_source_high = src6[127:64];
      p.v6_source_low = src6[63:0];
      p.v6_dest_high = dst6[127:64];
      p.v6_dest_low = dst6[63:0];
      if (pick < 42)
         p.ethertype = ETYPE_IPV4;
      else if (pick < 84)
         p.ethertype = ETYPE_IPV6;
      else if (pick < 92)
         p.ethertype = (pick[0] ? ETYPE_IPV4 : ETYPE_IPV6) ^ (16'h1 << $urandom_range(0, 15));
      else
         p.ethertype = 16'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 70)
         p.captured_len = 16'($urandom_range(MIN_LEN_V6, 16'hFFFF));
      else if (pick < 85)
         p.captured_len = 16'($urandom_range(MIN_LEN_V4 - 4, MIN_LEN_V6 + 4));
      else
         p.captured_len = 16'($urandom);
      return p;
   endfunction

   task automatic send_packet(input packet_desc_type p);
      while ($urandom_range(0, 99) < ((idle_mode == IDLE_SENDER) ? 46 :
                                      (idle_mode == IDLE_BOTH) ? 8 : 0)) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_egress <= p.egress;
      req_ethertype <= p.ethertype;
      req_frame_len <= p.frame_len;
      req_captured_len <= p.captured_len;
      req_v4_source <= p.v4_source;
      req_v4_dest <= p.v4_dest;
      req_v6_source_high <= p.v6_source_high;
      req_v6_source_low <= p.v6_source_low;
      req_v6_dest_high <= p.v6_dest_high;
      req_v6_dest_low <= p.v6_dest_low;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   initial begin : stimulus
      packet_desc_type p;
      ledger = new();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // IPv4 probes in and just outside the private ranges; egress and ingress alternate.
      for (int i = 0; i < 12; i++) begin
         p = random_packet();
         p.ethertype = ETYPE_IPV4;
         p.captured_len = (i == 0) ? MIN_LEN_V4 : 16'($urandom_range(MIN_LEN_V4, 16'hFFFF));
         p.egress = i[0];
         if (i[0])
            p.v4_dest = V4_PROBES[i];
         else
            p.v4_source = V4_PROBES[i];
         if (i == 0)
            p.frame_len = 16'd0;
         else if (i == 11)
            p.frame_len = 16'hFFFF;
         send_packet(p);
      end
      for (int i = 0; i < 7; i++) begin
         p = random_packet();
         p.ethertype = ETYPE_IPV6;
         p.captured_len = (i == 0) ? MIN_LEN_V6 : 16'hFFFF;
         p.egress = i[0];
         if (i[0]) begin
            {p.v6_dest_high, p.v6_dest_low} = V6_PROBES[i];
         end else begin
            {p.v6_source_high, p.v6_source_low} = V6_PROBES[i];
         end
         send_packet(p);
      end
      // Truncated headers one byte short of the minimum.
      p = random_packet();
      p.ethertype = ETYPE_IPV4;
      p.captured_len = MIN_LEN_V4 - 16'd1;
      send_packet(p);
      p = random_packet();
      p.ethertype = ETYPE_IPV6;
      p.captured_len = MIN_LEN_V6 - 16'd1;
      send_packet(p);
      // Unknown ethertypes with all fields at their extremes.
      p = '{1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, '1, '1, '1, '1, '1, '1};
      send_packet(p);
      p = '{1'b0, 16'h0000, 16'h0000, 16'h0000, '0, '0, '0, '0, '0, '0};
      send_packet(p);

      for (int round = 0; round < 8; round++) begin
         idle_mode = idle_mode_type'(round % 4);
         if (round == 4) begin
            // Hold the result side off while packets keep arriving back to back.
            idle_mode = IDLE_NONE;
            hold_off_start = 1'b1;
            repeat (100) send_packet(random_packet());
            idle_mode = idle_mode_type'(round % 4);
         end
         repeat (240) send_packet(random_packet());
      end
      req_valid <= 1'b0;
      idle_mode = IDLE_NONE;

      while (ledger.pending() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (ledger.failures == 0 && ledger.pending() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/pbac_pkg.sv
rtl/pbac_classify.sv
rtl/pbac_accum.sv
rtl/packet_byte_accounting_by_address_class.sv
rtl/pbac_checker.sv
dv/testbench.sv
